### rtl/kps_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, register codes, reset values and the key symbol table.
// ----------------------------------------------------------------------------
package kps_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SETTLE   = 3'd1,
    PH_SCAN     = 3'd2,
    PH_DEBOUNCE = 3'd3,
    PH_CONFIRM  = 3'd4,
    PH_RELCHK   = 3'd5,
    PH_RELWAIT  = 3'd6,
    PH_PAUSE    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_KEY     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SETTLE   = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_RELPOLL  = 2'd2,
    REG_PAUSE    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] SETTLE_RST   = 16'd3;
  localparam logic [15:0] DEBOUNCE_RST = 16'd2500;
  localparam logic [15:0] RELPOLL_RST  = 16'd1000;
  localparam logic [15:0] PAUSE_RST    = 16'd500;

  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] debounce_ticks;
    logic [15:0] release_poll_ticks;
    logic [15:0] pass_pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       busy_res;
    status_t    status;
    logic [6:0] key_code;
  } result_t;

  // A wait of zero ticks behaves as a wait of one tick.
  function automatic logic [15:0] load_wait(input logic [15:0] v);
    load_wait = (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [6:0] key_symbol(input logic [3:0] idx);
    logic [6:0] s;
    case (idx)
      4'd0:    s = 7'h31; // 1
      4'd1:    s = 7'h32; // 2
      4'd2:    s = 7'h33; // 3
      4'd3:    s = 7'h41; // A
      4'd4:    s = 7'h34; // 4
      4'd5:    s = 7'h35; // 5
      4'd6:    s = 7'h36; // 6
      4'd7:    s = 7'h42; // B
      4'd8:    s = 7'h37; // 7
      4'd9:    s = 7'h38; // 8
      4'd10:   s = 7'h39; // 9
      4'd11:   s = 7'h43; // C
      4'd12:   s = 7'h2A; // *
      4'd13:   s = 7'h30; // 0
      4'd14:   s = 7'h23; // #
      default: s = 7'h44; // D
    endcase
    key_symbol = s;
  endfunction

endpackage

### rtl/kps_regs.sv
// ----------------------------------------------------------------------------
// Keypad scanner configuration registers
// APB-style register file holding the four wait times.
// ----------------------------------------------------------------------------
module kps_regs import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks       <= SETTLE_RST;
      cfg.debounce_ticks     <= DEBOUNCE_RST;
      cfg.release_poll_ticks <= RELPOLL_RST;
      cfg.pass_pause_ticks   <= PAUSE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SETTLE:   cfg.settle_ticks       <= pwdata[15:0];
        REG_DEBOUNCE: cfg.debounce_ticks     <= pwdata[15:0];
        REG_RELPOLL:  cfg.release_poll_ticks <= pwdata[15:0];
        REG_PAUSE:    cfg.pass_pause_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETTLE:   prdata = {16'd0, cfg.settle_ticks};
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ticks};
      REG_RELPOLL:  prdata = {16'd0, cfg.release_poll_ticks};
      REG_PAUSE:    prdata = {16'd0, cfg.pass_pause_ticks};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

### rtl/kps_fsm.sv
// ----------------------------------------------------------------------------
// Keypad scanner sequencer
// Scan state and the one-tick update that produces each result.
// ----------------------------------------------------------------------------
module kps_fsm import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  cfg_t        cfg,
  input  logic        start_req,
  input  logic [23:0] timeout_limit,
  input  logic [3:0]  col_levels,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [1:0]  row_index, row_index_next;
  logic [1:0]  col_index, col_index_next;
  logic [15:0] wait_count, wait_count_next;
  logic [23:0] elapsed, elapsed_next;
  logic [23:0] timeout_hold, timeout_hold_next;
  logic [6:0]  found_key, found_key_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      row_index    <= 2'd0;
      col_index    <= 2'd0;
      wait_count   <= 16'd0;
      elapsed      <= 24'd0;
      timeout_hold <= 24'd0;
      found_key    <= 7'd0;
    end else if (step) begin
      phase        <= phase_next;
      row_index    <= row_index_next;
      col_index    <= col_index_next;
      wait_count   <= wait_count_next;
      elapsed      <= elapsed_next;
      timeout_hold <= timeout_hold_next;
      found_key    <= found_key_next;
    end
  end

  logic        col_low;
  logic [15:0] wc_dec;
  logic        wc_done;
  status_t     status;
  logic [6:0]  code;

  assign col_low = ~col_levels[col_index];
  assign wc_dec  = (wait_count != 16'd0) ? wait_count - 16'd1 : 16'd0;
  assign wc_done = (wc_dec == 16'd0);

  always_comb begin
    phase_next        = phase;
    row_index_next    = row_index;
    col_index_next    = col_index;
    wait_count_next   = wait_count;
    elapsed_next      = elapsed;
    timeout_hold_next = timeout_hold;
    found_key_next    = found_key;
    status            = ST_NONE;
    code              = 7'd0;

    if (phase == PH_IDLE) begin
      if (start_req) begin
        timeout_hold_next = timeout_limit;
        elapsed_next      = 24'd0;
        found_key_next    = 7'd0;
        row_index_next    = 2'd0;
        col_index_next    = 2'd0;
        wait_count_next   = load_wait(cfg.settle_ticks);
        phase_next        = PH_SETTLE;
      end
    end else begin
      if (elapsed != ELAPSED_MAX) begin
        elapsed_next = elapsed + 24'd1;
      end
      case (phase)
        PH_SETTLE, PH_DEBOUNCE, PH_RELWAIT: begin
          wait_count_next = wc_dec;
          if (wc_done) begin
            case (phase)
              PH_SETTLE:   phase_next = PH_SCAN;
              PH_DEBOUNCE: phase_next = PH_CONFIRM;
              default:     phase_next = PH_RELCHK;
            endcase
          end
        end
        PH_SCAN, PH_CONFIRM: begin
          if (col_low && phase == PH_SCAN) begin
            wait_count_next = load_wait(cfg.debounce_ticks);
            phase_next      = PH_DEBOUNCE;
          end else if (col_low) begin
            found_key_next = key_symbol({row_index, col_index});
            phase_next     = PH_RELCHK;
          end else if (col_index != 2'd3) begin
            col_index_next = col_index + 2'd1;
            phase_next     = PH_SCAN;
          end else if (row_index == 2'd3) begin
            col_index_next  = 2'd0;
            wait_count_next = load_wait(cfg.pass_pause_ticks);
            phase_next      = PH_PAUSE;
          end else begin
            row_index_next  = row_index + 2'd1;
            col_index_next  = 2'd0;
            wait_count_next = load_wait(cfg.settle_ticks);
            phase_next      = PH_SETTLE;
          end
        end
        PH_RELCHK: begin
          if (col_low) begin
            wait_count_next = load_wait(cfg.release_poll_ticks);
            phase_next      = PH_RELWAIT;
          end else begin
            status     = ST_KEY;
            code       = found_key;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          wait_count_next = wc_dec;
          if (wc_done) begin
            if (elapsed_next < timeout_hold) begin
              row_index_next  = 2'd0;
              col_index_next  = 2'd0;
              wait_count_next = load_wait(cfg.settle_ticks);
              phase_next      = PH_SETTLE;
            end else begin
              status     = ST_TIMEOUT;
              phase_next = PH_IDLE;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    res.status   = status;
    res.key_code = code;
    if (phase_next == PH_IDLE) begin
      res.row_drive = 4'hF;
      res.busy_res  = 1'b0;
    end else begin
      res.row_drive = ~(4'b0001 << row_index_next);
      res.busy_res  = 1'b1;
    end
  end

endmodule

### rtl/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// Matrix keypad scanner, 4x4
// Streams one result per tick; scans rows, debounces and reports keys.
// ----------------------------------------------------------------------------
// Each transfer on the input stream is one time tick carrying the sampled
// column levels; each tick yields exactly one transfer on the output stream
// with the row drive, busy flag, status and key symbol after that tick. A
// tick is registered on entry, and the scan state is updated and the result
// registered as the tick leaves the input register, so the block takes one
// tick per clock while the output is free. The wait times must be written
// through the APB port only while no read is in progress; the user must
// ensure this, as the block itself does not enforce it.
module matrix_keypad_scanner import kps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // timeout_limit[23:0], col_levels[27:24]
  input  logic        s_axis_tuser,  // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // row_drive[3:0], busy_res[4], key_code[11:5]
  output logic [1:0]  m_axis_tuser,  // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  result_t     res;
  logic        in_valid;
  logic        in_start;
  logic [23:0] in_limit;
  logic [3:0]  in_cols;
  logic        advance;

  assign advance       = in_valid & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_start <= s_axis_tuser;
      in_limit <= s_axis_tdata[23:0];
      in_cols  <= s_axis_tdata[27:24];
    end
  end

  kps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kps_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .cfg           (cfg),
    .start_req     (in_start),
    .timeout_limit (in_limit),
    .col_levels    (in_cols),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (~m_axis_tvalid | m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {4'd0, res.key_code, res.busy_res, res.row_drive};
      m_axis_tuser <= res.status;
    end
  end

  a_key_has_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_KEY) |-> (m_axis_tdata[11:5] != 7'd0))
    else $error("key reported without a symbol");

  a_report_ends_read: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_NONE) |-> !m_axis_tdata[4])
    else $error("read still busy after a report");

  a_idle_rows_high: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[3:0] == 4'hF))
    else $error("row driven while idle");

  a_one_row_low: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |-> ($countones(m_axis_tdata[3:0]) == 3))
    else $error("busy without exactly one row driven");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad scanner testbench
// Drives time ticks into the 4x4 keypad scanner from a model of a physical
// keypad that follows the row drive, predicts every per-tick result and
// checks each output transfer field by field. It covers directed reads at the
// reset settle time with short waits, random reads under several wait
// settings and idling patterns, and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import kps_pkg::*;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  class scan_predictor;
    logic [15:0] settle_ticks, debounce_ticks, relpoll_ticks, pause_ticks;
    phase_t      scan_phase;
    logic [1:0]  row;
    logic [2:0]  col;
    logic [15:0] wait_cnt;
    logic [23:0] elapsed;
    logic [23:0] limit_hold;
    logic [6:0]  held_key;
    string       key_chars;
    result_t     tick_results[$];
    int          errors, ticks, checked, keys_seen, timeouts_seen;

    function new();
      settle_ticks   = SETTLE_RST;
      debounce_ticks = DEBOUNCE_RST;
      relpoll_ticks  = RELPOLL_RST;
      pause_ticks    = PAUSE_RST;
      scan_phase     = PH_IDLE;
      row            = '0;
      col            = '0;
      wait_cnt       = '0;
      elapsed        = '0;
      limit_hold     = '0;
      held_key       = '0;
      key_chars      = "123A456B789C*0#D";
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_SETTLE:   settle_ticks = v;
        REG_DEBOUNCE: debounce_ticks = v;
        REG_RELPOLL:  relpoll_ticks = v;
        REG_PAUSE:    pause_ticks = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] at_least_one(logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function bit wait_done();
      if (wait_cnt != 16'd0) wait_cnt--;
      return wait_cnt == 16'd0;
    endfunction

    function void enter_row(logic [1:0] r);
      row        = r;
      col        = '0;
      wait_cnt   = at_least_one(settle_ticks);
      scan_phase = PH_SETTLE;
    endfunction

    function void advance_col();
      col = col + 3'd1;
      if (col >= 3'd4) begin
        if (row == 2'd3) begin
          col        = '0;
          wait_cnt   = at_least_one(pause_ticks);
          scan_phase = PH_PAUSE;
        end else begin
          enter_row(row + 2'd1);
        end
      end else begin
        scan_phase = PH_SCAN;
      end
    endfunction

    function logic [3:0] rows_out();
      return (scan_phase == PH_IDLE) ? 4'hF : ~(4'b0001 << row);
    endfunction

    function bit busy();
      return scan_phase != PH_IDLE;
    endfunction

    function int pending();
      return tick_results.size();
    endfunction

    function void note_tick(bit start, logic [23:0] limit, logic [3:0] cols);
      result_t    r;
      status_t    st;
      logic [6:0] code;
      bit         low;
      st   = ST_NONE;
      code = '0;
      low  = !cols[col[1:0]];
      ticks++;
      if (scan_phase == PH_IDLE) begin
        if (start) begin
          limit_hold = limit;
          elapsed    = '0;
          held_key   = '0;
          enter_row(2'd0);
        end
      end else begin
        if (elapsed != ELAPSED_MAX) elapsed++;
        case (scan_phase)
          PH_SETTLE: if (wait_done()) scan_phase = PH_SCAN;
          PH_SCAN: begin
            if (low) begin
              wait_cnt   = at_least_one(debounce_ticks);
              scan_phase = PH_DEBOUNCE;
            end else begin
              advance_col();
            end
          end
          PH_DEBOUNCE: if (wait_done()) scan_phase = PH_CONFIRM;
          PH_CONFIRM: begin
            if (low) begin
              held_key   = 7'(key_chars[{row, col[1:0]}]);
              scan_phase = PH_RELCHK;
            end else begin
              advance_col();
            end
          end
          PH_RELCHK: begin
            if (low) begin
              wait_cnt   = at_least_one(relpoll_ticks);
              scan_phase = PH_RELWAIT;
            end else begin
              st         = ST_KEY;
              code       = held_key;
              scan_phase = PH_IDLE;
            end
          end
          PH_RELWAIT: if (wait_done()) scan_phase = PH_RELCHK;
          PH_PAUSE: begin
            if (wait_done()) begin
              if (elapsed < limit_hold) begin
                enter_row(2'd0);
              end else begin
                st         = ST_TIMEOUT;
                scan_phase = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      r.row_drive = rows_out();
      r.busy_res  = busy();
      r.status    = st;
      r.key_code  = code;
      tick_results.push_back(r);
    endfunction

    function void report(string field, logic [6:0] want, logic [6:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [15:0] data, logic [1:0] flags);
      result_t want;
      if (tick_results.size() == 0) begin
        errors++;
        $display("%0t: result with no tick pending, expected none, actual %h/%0h",
                 $time, data, flags);
        return;
      end
      want = tick_results.pop_front();
      checked++;
      if (flags == ST_KEY) keys_seen++;
      if (flags == ST_TIMEOUT) timeouts_seen++;
      if (data[3:0] !== want.row_drive)
        report("row_drive", 7'(want.row_drive), 7'(data[3:0]));
      if (data[4] !== want.busy_res)
        report("busy_res", 7'(want.busy_res), 7'(data[4]));
      if (flags !== want.status)
        report("status", 7'(want.status), 7'(flags));
      if (data[11:5] !== want.key_code) report("key_code", want.key_code, data[11:5]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scan_predictor sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit holdoff_req = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  matrix_keypad_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_ready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      stall_left  = HOLDOFF_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Column levels seen on the pins when one key is held on the keypad.
  function automatic logic [3:0] keypad_cols(bit pressed, int krow, int kcol);
    logic [3:0] rows;
    rows = sb.rows_out();
    if (pressed && !rows[krow]) return ~(4'b0001 << kcol);
    return 4'hF;
  endfunction

  task automatic send_tick(bit start, logic [23:0] limit, logic [3:0] cols);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0000, cols, limit};
    s_user  <= start;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(start, limit, cols);
  endtask

  task automatic press_until(int krow, int kcol, bit pressed, phase_t stop, int max_ticks);
    int n;
    n = 0;
    while (sb.scan_phase != stop && n < max_ticks) begin
      send_tick(1'b0, 24'($urandom_range(0, 24'hFFFFFF)),
                keypad_cols(pressed, krow, kcol));
      n++;
    end
  endtask

  // Ends any read in progress: every column reads low until a key is held,
  // then all columns are released.
  task automatic drain();
    while (sb.busy()) begin
      if (sb.scan_phase == PH_RELCHK || sb.scan_phase == PH_RELWAIT)
        send_tick(1'b0, '0, 4'hF);
      else
        send_tick(1'b0, '0, 4'h0);
    end
  endtask

  task automatic quiesce();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [15:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_waits(logic [15:0] s, logic [15:0] d, logic [15:0] r, logic [15:0] p);
    reg_write(REG_SETTLE, s);
    reg_write(REG_DEBOUNCE, d);
    reg_write(REG_RELPOLL, r);
    reg_write(REG_PAUSE, p);
  endtask

  task automatic random_ticks(int count);
    int         i;
    int         hold_left;
    int         krow, kcol;
    logic [3:0] cols;
    logic [23:0] limit;
    bit         start;
    hold_left = 0;
    krow = 0;
    kcol = 0;
    for (i = 0; i < count; i++) begin
      if (hold_left == 0 && $urandom_range(0, 11) == 0) begin
        krow      = $urandom_range(0, 3);
        kcol      = $urandom_range(0, 3);
        hold_left = $urandom_range(1, 40);
      end
      cols = keypad_cols(hold_left > 0, krow, kcol);
      if ($urandom_range(0, 9) == 0) cols = 4'($urandom_range(0, 15));
      start = sb.busy() ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0:       limit = '0;
        1:       limit = 24'($urandom_range(0, 24'hFFFFFF));
        default: limit = 24'($urandom_range(0, 120));
      endcase
      send_tick(start, limit, cols);
      if (hold_left > 0) hold_left--;
    end
  endtask

  task automatic random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    random_ticks(count);
    drain();
    quiesce();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reads at the reset settle time with short waits.
    reg_write(REG_DEBOUNCE, 16'd6);
    reg_write(REG_RELPOLL, 16'd4);
    reg_write(REG_PAUSE, 16'd5);
    send_tick(1'b1, 24'h000000, 4'hF);
    press_until(0, 0, 1'b0, PH_IDLE, 5000);
    send_tick(1'b0, 24'hFFFFFF, 4'h0);
    send_tick(1'b0, 24'h000000, 4'hA);
    send_tick(1'b1, 24'hFFFFFF, 4'hF);
    send_tick(1'b1, 24'h000001, 4'hF);
    press_until(3, 3, 1'b1, PH_RELCHK, 20000);
    press_until(3, 3, 1'b1, PH_RELWAIT, 10);
    press_until(3, 3, 1'b1, PH_RELCHK, 5000);
    press_until(3, 3, 1'b0, PH_IDLE, 10);
    send_tick(1'b1, 24'h000001, 4'hF);
    press_until(1, 2, 1'b1, PH_DEBOUNCE, 5000);
    press_until(1, 2, 1'b0, PH_IDLE, 20000);
    send_tick(1'b1, 24'd100, 4'hF);
    press_until(0, 0, 1'b1, PH_RELCHK, 5000);
    press_until(0, 0, 1'b0, PH_IDLE, 10);
    drain();
    quiesce();

    set_waits(16'd1, 16'd1, 16'd1, 16'd1);
    holdoff_req = 1'b1;
    random_phase(0, 0, 80);

    set_waits(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(74, 0, 70);

    set_waits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
    random_phase(0, 74, 80);

    set_waits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
    random_phase(31, 31, 80);

    $display("Sent %0d ticks and checked %0d results under five wait settings.",
             sb.ticks, sb.checked);
    $display("Reads ended with %0d key reports and %0d timeouts.",
             sb.keys_seen, sb.timeouts_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/kps_pkg.sv
rtl/kps_regs.sv
rtl/kps_fsm.sv
rtl/matrix_keypad_scanner.sv
tb/testbench.sv
